[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the warp block. Both sample on the rising
// edge of clk; the first is gated off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that only has to hold out of reset.
`define PWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that has to hold during reset as well.
`define PWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pwb_pkg.sv]
// ----------------------------------------------------------------------------
// pwb_pkg
// Shared types and fixed widths of the perspective warp block.
// ----------------------------------------------------------------------------
package pwb_pkg;

  localparam int COEF_W = 32;
  localparam int CRD_W  = 12;
  localparam int PIX_W  = 32;
  localparam int PROD_W = 45;  // 32-bit signed coefficient times 13-bit signed coordinate
  localparam int SUM_W  = 47;  // sum of two products and one coefficient

  typedef enum logic [2:0] {
    CFG_A11_A12,
    CFG_A13_A21,
    CFG_A22_A23,
    CFG_A31_A32,
    CFG_A33,
    CFG_SIZE,
    CFG_FORMAT,
    CFG_FILL
  } cfg_idx_t;

  typedef enum logic {
    MODE_LOAD,
    MODE_WARP
  } mode_t;

  typedef struct packed {
    logic [COEF_W-1:0] a11;
    logic [COEF_W-1:0] a12;
    logic [COEF_W-1:0] a13;
    logic [COEF_W-1:0] a21;
    logic [COEF_W-1:0] a22;
    logic [COEF_W-1:0] a23;
    logic [COEF_W-1:0] a31;
    logic [COEF_W-1:0] a32;
    logic [COEF_W-1:0] a33;
  } coef_t;

  typedef struct packed {
    mode_t             mode;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [PIX_W-1:0]  pix;
  } item_t;

  typedef struct packed {
    logic [15:0]      width;
    logic [15:0]      height;
    logic [PIX_W-1:0] chan_mask;
    logic             fill_en;
    logic [PIX_W-1:0] fill;
  } cfg_view_t;

endpackage

[rtl/perspective_warp_bilinear_top.sv]
// ----------------------------------------------------------------------------
// perspective_warp_bilinear_top
// Perspective warp of a stored source image with bilinear resampling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries mode, coord_x, coord_y and
//   pixel_in. A load item (mode 0) writes one source pixel and gives no
//   result; a warp item (mode 1) gives one result on the output channel
//   (out_valid / out_stall): pixel_out and write_enable.
//   The config port (cfg_we, cfg_index, cfg_data) writes one register per
//   cycle; write it only while no item is in flight.
//   Throughput: one item per cycle in either mode while the receiver does not stall.
//   A warp result passes the input register, the homography stages, the
//   divider (an overflow-check stage, then QB = clog2(max(MAX_WIDTH,
//   MAX_HEIGHT)) + FRAC_BITS + 1 bit-per-stage steps), the sample stages
//   and the output register.
//   Reset clears all valid bits and loads the identity warp, a 256x256
//   one-channel image and no fill. Source memory is not cleared: a pixel
//   reads back only after it has been loaded.
//   When the receiver stalls with a result held, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module perspective_warp_bilinear_top import pwb_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int FRAC_BITS    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [CRD_W-1:0] coord_x,
  input  logic [CRD_W-1:0] coord_y,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             write_enable
);

`include "assert_macros.svh"

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QB   = $clog2(MAXD) + FRAC_BITS + 1;
  localparam int NW   = SUM_W + FRAC_BITS;
  localparam int SBW  = $bits(item_t) + 3;

  // Configuration registers
  logic [63:0] c_a11_a12, c_a13_a21, c_a22_a23, c_a31_a32;
  logic [31:0] c_a33, c_size, c_fill;
  logic [3:0]  c_fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_a11_a12 <= 64'd1048576;
      c_a13_a21 <= 64'd0;
      c_a22_a23 <= 64'd1048576;
      c_a31_a32 <= 64'd0;
      c_a33     <= 32'd1048576;
      c_size    <= 32'd16777472;
      c_fmt     <= 4'd1;
      c_fill    <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A11_A12: c_a11_a12 <= cfg_data;
        CFG_A13_A21: c_a13_a21 <= cfg_data;
        CFG_A22_A23: c_a22_a23 <= cfg_data;
        CFG_A31_A32: c_a31_a32 <= cfg_data;
        CFG_A33:     c_a33     <= cfg_data[31:0];
        CFG_SIZE:    c_size    <= cfg_data[31:0];
        CFG_FORMAT:  c_fmt     <= cfg_data[3:0];
        CFG_FILL:    c_fill    <= cfg_data[31:0];
        default:     c_fill    <= c_fill;
      endcase
    end
  end

  coef_t     coef;
  cfg_view_t cview;
  logic [2:0]       cnc;
  logic [PIX_W-1:0] chan_mask;

  assign coef = '{
    a11: c_a11_a12[31:0], a12: c_a11_a12[63:32],
    a13: c_a13_a21[31:0], a21: c_a13_a21[63:32],
    a22: c_a22_a23[31:0], a23: c_a22_a23[63:32],
    a31: c_a31_a32[31:0], a32: c_a31_a32[63:32],
    a33: c_a33
  };

  // Channel count: zero means one, clip at the lane count.
  always_comb begin
    cnc = c_fmt[2:0];
    if (c_fmt[2:0] == 3'd0) begin
      cnc = 3'd1;
    end else if (c_fmt[2:0] > 3'(MAX_CHANNELS)) begin
      cnc = 3'(MAX_CHANNELS);
    end
    for (int k = 0; k < 4; k++) begin
      chan_mask[8*k +: 8] = (3'(k) < cnc) ? 8'hFF : 8'h00;
    end
  end

  assign cview = '{
    width:     c_size[15:0],
    height:    c_size[31:16],
    chan_mask: chan_mask,
    fill_en:   c_fmt[3],
    fill:      c_fill
  };

  // Advance everything unless a held result is being refused.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input register
  logic  in_vld_q;
  item_t in_item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item_q <= '{mode: mode_t'(mode), x: coord_x, y: coord_y, pix: pixel_in};
    end
  end

  // Homography and divide operands
  logic          xf_vld, neg_x, neg_y, den_zero;
  item_t         xf_item;
  logic [NW-1:0] num_x, num_y;
  logic [SUM_W-1:0] den;

  pwb_xform #(.FB(FRAC_BITS)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (in_vld_q),
    .in_item  (in_item_q),
    .coef     (coef),
    .out_vld  (xf_vld),
    .out_item (xf_item),
    .num_x    (num_x),
    .num_y    (num_y),
    .den      (den),
    .neg_x    (neg_x),
    .neg_y    (neg_y),
    .den_zero (den_zero)
  );

  // Divide X*S and Y*S by W
  logic           dv_vld, rnz_x, rnz_y, ovf_x, ovf_y;
  logic [QB-1:0]  q_x, q_y;
  logic [SBW-1:0] dv_sb;
  item_t          dv_item;
  logic           dv_zero, dv_negx, dv_negy;

  pwb_div #(.NW(NW), .DW(SUM_W), .QB(QB), .SBW(SBW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (xf_vld),
    .num_x   (num_x),
    .num_y   (num_y),
    .den     (den),
    .in_sb   ({den_zero, neg_x, neg_y, xf_item}),
    .out_vld (dv_vld),
    .q_x     (q_x),
    .q_y     (q_y),
    .rnz_x   (rnz_x),
    .rnz_y   (rnz_y),
    .ovf_x   (ovf_x),
    .ovf_y   (ovf_y),
    .out_sb  (dv_sb)
  );

  assign {dv_zero, dv_negx, dv_negy, dv_item} = dv_sb;

  // Clamp, memory access and blend
  logic             res_vld, res_we;
  logic [PIX_W-1:0] res_pixel;

  pwb_sample #(
    .MAXW (MAX_WIDTH),
    .MAXH (MAX_HEIGHT),
    .MAXC (MAX_CHANNELS),
    .FB   (FRAC_BITS),
    .QB   (QB)
  ) u_sample (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_vld    (dv_vld),
    .in_item   (dv_item),
    .q_x       (q_x),
    .q_y       (q_y),
    .rnz_x     (rnz_x),
    .rnz_y     (rnz_y),
    .neg_x     (dv_negx),
    .neg_y     (dv_negy),
    .bad       (dv_zero || ovf_x || ovf_y),
    .cfg       (cview),
    .res_vld   (res_vld),
    .res_pixel (res_pixel),
    .res_we    (res_we)
  );

  // Output register: hold while refused, else take the next result or bubble.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out    <= res_pixel;
      write_enable <= res_we;
    end
  end

  `PWB_ASSERT(a_nowrite_zero, out_valid && !write_enable |-> pixel_out == '0, "skipped write carries data")
  `PWB_ASSERT(a_nowrite_nofill, out_valid && !write_enable |-> !c_fmt[3], "skipped write with fill on")
  `PWB_ASSERT(a_unused_chan, out_valid |-> (pixel_out & ~chan_mask) == '0, "unused channel not zero")
  `PWB_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid && !in_vld_q, "valid after reset")

endmodule

[rtl/pwb_xform.sv]
// ----------------------------------------------------------------------------
// pwb_xform
// Homography front end: six products, three sums, then sign and magnitude
// of the divide operands. Three register stages.
// ----------------------------------------------------------------------------
module pwb_xform import pwb_pkg::*; #(
  parameter int FB = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  item_t               in_item,
  input  coef_t               coef,
  output logic                out_vld,
  output item_t               out_item,
  output logic [SUM_W+FB-1:0] num_x,
  output logic [SUM_W+FB-1:0] num_y,
  output logic [SUM_W-1:0]    den,
  output logic                neg_x,
  output logic                neg_y,
  output logic                den_zero
);

  logic signed [CRD_W:0]    xs, ys;
  logic signed [PROD_W-1:0] prod [6];
  logic                     s1_vld, s2_vld;
  item_t                    s1_item, s2_item;
  logic signed [SUM_W-1:0]  s2_x, s2_y, s2_w;
  logic [SUM_W-1:0]         mag_x, mag_y, mag_w;

  assign xs = $signed({1'b0, in_item.x});
  assign ys = $signed({1'b0, in_item.y});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= $signed(coef.a11) * xs;
      prod[1] <= $signed(coef.a12) * ys;
      prod[2] <= $signed(coef.a21) * xs;
      prod[3] <= $signed(coef.a22) * ys;
      prod[4] <= $signed(coef.a31) * xs;
      prod[5] <= $signed(coef.a32) * ys;
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x    <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'($signed(coef.a13));
      s2_y    <= SUM_W'(prod[2]) + SUM_W'(prod[3]) + SUM_W'($signed(coef.a23));
      s2_w    <= SUM_W'(prod[4]) + SUM_W'(prod[5]) + SUM_W'($signed(coef.a33));
      s2_item <= s1_item;
    end
  end

  assign mag_x = s2_x[SUM_W-1] ? SUM_W'(-s2_x) : SUM_W'(s2_x);
  assign mag_y = s2_y[SUM_W-1] ? SUM_W'(-s2_y) : SUM_W'(s2_y);
  assign mag_w = s2_w[SUM_W-1] ? SUM_W'(-s2_w) : SUM_W'(s2_w);

  always_ff @(posedge clk) begin
    if (en) begin
      num_x    <= {mag_x, {FB{1'b0}}};
      num_y    <= {mag_y, {FB{1'b0}}};
      den      <= mag_w;
      neg_x    <= s2_x[SUM_W-1] ^ s2_w[SUM_W-1];
      neg_y    <= s2_y[SUM_W-1] ^ s2_w[SUM_W-1];
      den_zero <= (s2_w == '0);
      out_item <= s2_item;
    end
  end

endmodule

[rtl/pwb_div.sv]
// ----------------------------------------------------------------------------
// pwb_div
// Pipelined restoring divider, two numerators over one shared divisor.
// One quotient bit per stage after an overflow-check stage.
// ----------------------------------------------------------------------------
module pwb_div #(
  parameter int NW  = 55,
  parameter int DW  = 47,
  parameter int QB  = 17,
  parameter int SBW = 60
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  num_x,
  input  logic [NW-1:0]  num_y,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QB-1:0]  q_x,
  output logic [QB-1:0]  q_y,
  output logic           rnz_x,
  output logic           rnz_y,
  output logic           ovf_x,
  output logic           ovf_y,
  output logic [SBW-1:0] out_sb
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic           vld [QB+1];
  logic [CW-1:0]  rx  [QB+1];
  logic [CW-1:0]  ry  [QB+1];
  logic [QB-1:0]  qx  [QB+1];
  logic [QB-1:0]  qy  [QB+1];
  logic           ox  [QB+1];
  logic           oy  [QB+1];
  logic [DW-1:0]  dv  [QB+1];
  logic [SBW-1:0] sb  [QB+1];

  // Quotient overflows when num >= den * 2^QB.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= CW'(num_x);
      ry[0] <= CW'(num_y);
      qx[0] <= '0;
      qy[0] <= '0;
      ox[0] <= (CW'(num_x) >> QB) >= CW'(den);
      oy[0] <= (CW'(num_y) >> QB) >= CW'(den);
      dv[0] <= den;
      sb[0] <= in_sb;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int BI = QB - 1 - s;
    logic [CW-1:0] dsh;
    logic          gx, gy;

    assign dsh = CW'(dv[s]) << BI;
    assign gx  = rx[s] >= dsh;
    assign gy  = ry[s] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[s+1] <= gx ? rx[s] - dsh : rx[s];
        ry[s+1] <= gy ? ry[s] - dsh : ry[s];
        qx[s+1] <= qx[s] | (QB'(gx) << BI);
        qy[s+1] <= qy[s] | (QB'(gy) << BI);
        ox[s+1] <= ox[s];
        oy[s+1] <= oy[s];
        dv[s+1] <= dv[s];
        sb[s+1] <= sb[s];
      end
    end
  end

  assign out_vld = vld[QB];
  assign q_x     = qx[QB];
  assign q_y     = qy[QB];
  assign rnz_x   = |rx[QB];
  assign rnz_y   = |ry[QB];
  assign ovf_x   = ox[QB];
  assign ovf_y   = oy[QB];
  assign out_sb  = sb[QB];

endmodule

[rtl/pwb_sample.sv]
// ----------------------------------------------------------------------------
// pwb_sample
// Floor fixup, border clamp, four parity-banked source memories and the
// two-step bilinear blend. Five register stages.
// ----------------------------------------------------------------------------
module pwb_sample import pwb_pkg::*; #(
  parameter int MAXW = 256,
  parameter int MAXH = 256,
  parameter int MAXC = 4,
  parameter int FB   = 8,
  parameter int QB   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  item_t            in_item,
  input  logic [QB-1:0]    q_x,
  input  logic [QB-1:0]    q_y,
  input  logic             rnz_x,
  input  logic             rnz_y,
  input  logic             neg_x,
  input  logic             neg_y,
  input  logic             bad,
  input  cfg_view_t        cfg,
  output logic             res_vld,
  output logic [PIX_W-1:0] res_pixel,
  output logic             res_we
);

  localparam int PW     = QB + 1;
  localparam int IW     = PW - FB;
  localparam int XW     = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam int YW     = (MAXH > 1) ? $clog2(MAXH) : 1;
  localparam int HWID   = (MAXW + 1) / 2;
  localparam int HHGT   = (MAXH + 1) / 2;
  localparam int BDEPTH = HWID * HHGT;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int DWID   = 8 * MAXC;
  localparam int P0W    = FB + 10;
  localparam int P1W    = P0W + 1;
  localparam int VW     = 2 * FB + 12;
  localparam logic [VW-1:0] HALF = VW'(1) << (2 * FB - 1);

  function automatic logic [BAW-1:0] bank_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return BAW'(32'(y >> 1) * HWID + 32'(x >> 1));
  endfunction

  // ---- P1: signed floor of the quotients
  logic                 p1_vld, p1_bad;
  item_t                p1_item;
  logic [PW-1:0]        qe_x, qe_y;
  logic signed [PW-1:0] p1_px, p1_py;

  assign qe_x = {1'b0, q_x} + PW'(rnz_x);
  assign qe_y = {1'b0, q_y} + PW'(rnz_y);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_px   <= neg_x ? $signed(-qe_x) : $signed({1'b0, q_x});
      p1_py   <= neg_y ? $signed(-qe_y) : $signed({1'b0, q_y});
      p1_bad  <= bad;
      p1_item <= in_item;
    end
  end

  // ---- P2: range check, clamp, bank addresses
  logic [15:0]          wc, hc;
  logic [XW-1:0]        wm1;
  logic [YW-1:0]        hm1;
  logic signed [IW-1:0] ix, iy, ixp1, iyp1;
  logic                 in_x, in_y, ld_in;
  logic [XW-1:0]        x0, x1, lx;
  logic [YW-1:0]        y0, y1, ly;
  logic [BAW-1:0]       addr_c [4];
  logic                 wen_c  [4];

  logic                 p2_vld, p2_out, p2_warp;
  logic                 p2_x0p, p2_x1p, p2_y0p, p2_y1p;
  logic [FB-1:0]        p2_fa, p2_fb;
  logic [BAW-1:0]       p2_addr [4];
  logic                 p2_wen  [4];
  logic [DWID-1:0]      p2_wdata;

  always_comb begin
    wc = cfg.width;
    if (cfg.width < 16'd2) begin
      wc = 16'd2;
    end else if (cfg.width > 16'(MAXW)) begin
      wc = 16'(MAXW);
    end
    hc = cfg.height;
    if (cfg.height < 16'd2) begin
      hc = 16'd2;
    end else if (cfg.height > 16'(MAXH)) begin
      hc = 16'(MAXH);
    end
  end

  assign wm1  = XW'(wc - 16'd1);
  assign hm1  = YW'(hc - 16'd1);
  assign ix   = $signed(p1_px[PW-1:FB]);
  assign iy   = $signed(p1_py[PW-1:FB]);
  assign ixp1 = ix + IW'(1);
  assign iyp1 = iy + IW'(1);
  assign in_x = (ix >= -IW'(1)) && (ix <= $signed(IW'(wm1)));
  assign in_y = (iy >= -IW'(1)) && (iy <= $signed(IW'(hm1)));
  assign x0   = ix[IW-1] ? '0 : ix[XW-1:0];
  assign y0   = iy[IW-1] ? '0 : iy[YW-1:0];
  assign x1   = (ixp1 > $signed(IW'(wm1))) ? wm1 : ixp1[XW-1:0];
  assign y1   = (iyp1 > $signed(IW'(hm1))) ? hm1 : iyp1[YW-1:0];
  assign lx   = XW'(p1_item.x);
  assign ly   = YW'(p1_item.y);
  assign ld_in = (32'(p1_item.x) < 32'(MAXW)) && (32'(p1_item.y) < 32'(MAXH));

  // Bank {y[0], x[0]} holds the pixels of that parity; the two neighbours on
  // each axis differ in parity unless clamped onto one pixel.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic          bx, by;
      logic [XW-1:0] xs;
      logic [YW-1:0] ys;
      bx = 1'(b & 1);
      by = 1'((b >> 1) & 1);
      xs = (x0[0] == bx) ? x0 : x1;
      ys = (y0[0] == by) ? y0 : y1;
      addr_c[b] = (p1_item.mode == MODE_WARP) ? bank_addr(xs, ys) : bank_addr(lx, ly);
      wen_c[b]  = (p1_item.mode == MODE_LOAD) && ld_in && (lx[0] == bx) && (ly[0] == by);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_out   <= p1_bad || !in_x || !in_y;
      p2_warp  <= (p1_item.mode == MODE_WARP);
      p2_x0p   <= x0[0];
      p2_x1p   <= x1[0];
      p2_y0p   <= y0[0];
      p2_y1p   <= y1[0];
      p2_fa    <= p1_px[FB-1:0];
      p2_fb    <= p1_py[FB-1:0];
      p2_wdata <= p1_item.pix[DWID-1:0];
      for (int b = 0; b < 4; b++) begin
        p2_addr[b] <= addr_c[b];
        p2_wen[b]  <= wen_c[b];
      end
    end
  end

  // ---- P3: bank write and registered read
  logic [DWID-1:0] rd_all [4];
  logic            p3_vld, p3_out, p3_warp;
  logic            p3_x0p, p3_x1p, p3_y0p, p3_y1p;
  logic [FB-1:0]   p3_fa, p3_fb;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [DWID-1:0] mem [BDEPTH];
    logic [DWID-1:0] rdq;

    always_ff @(posedge clk) begin
      if (en && p2_vld && p2_wen[b]) begin
        mem[p2_addr[b]] <= p2_wdata;
      end
      if (en) begin
        rdq <= mem[p2_addr[b]];
      end
    end

    assign rd_all[b] = rdq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_out  <= p2_out;
      p3_warp <= p2_warp;
      p3_x0p  <= p2_x0p;
      p3_x1p  <= p2_x1p;
      p3_y0p  <= p2_y0p;
      p3_y1p  <= p2_y1p;
      p3_fa   <= p2_fa;
      p3_fb   <= p2_fb;
    end
  end

  // ---- P4 / P5: horizontal then vertical blend, one lane per channel
  logic            p4_vld, p4_out, p4_warp;
  logic [FB-1:0]   p4_fb;
  logic            p5_vld, p5_out, p5_warp;
  logic [DWID-1:0] interp;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_out  <= p3_out;
      p4_warp <= p3_warp;
      p4_fb   <= p3_fb;
      p5_out  <= p4_out;
      p5_warp <= p4_warp;
    end
  end

  for (genvar k = 0; k < MAXC; k++) begin : g_lane
    logic [7:0]            v00, v10, v01, v11;
    logic signed [8:0]     d0, d1;
    logic signed [FB:0]    fa_s, fb_s;
    logic signed [P0W-1:0] m0, m1, p0, p1;
    logic signed [P1W-1:0] dv;
    logic signed [VW-1:0]  m2, v;
    logic [VW-1:0]         rv;
    logic [VW-2*FB-1:0]    r_w;
    logic [7:0]            r;

    assign v00  = rd_all[{p3_y0p, p3_x0p}][8*k +: 8];
    assign v10  = rd_all[{p3_y0p, p3_x1p}][8*k +: 8];
    assign v01  = rd_all[{p3_y1p, p3_x0p}][8*k +: 8];
    assign v11  = rd_all[{p3_y1p, p3_x1p}][8*k +: 8];
    assign d0   = $signed({1'b0, v10}) - $signed({1'b0, v00});
    assign d1   = $signed({1'b0, v11}) - $signed({1'b0, v01});
    assign fa_s = $signed({1'b0, p3_fa});
    assign m0   = fa_s * d0;
    assign m1   = fa_s * d1;

    always_ff @(posedge clk) begin
      if (en) begin
        p0 <= $signed(P0W'({v00, {FB{1'b0}}})) + m0;
        p1 <= $signed(P0W'({v01, {FB{1'b0}}})) + m1;
      end
    end

    assign fb_s = $signed({1'b0, p4_fb});
    assign dv   = P1W'(p1) - P1W'(p0);
    assign m2   = fb_s * dv;

    always_ff @(posedge clk) begin
      if (en) begin
        v <= (VW'(p0) <<< FB) + m2;
      end
    end

    // Round half up, then keep the integer part.
    assign rv  = v + $signed(HALF);
    assign r_w = rv[VW-1:2*FB];
    assign r   = (r_w > (VW-2*FB)'(255)) ? 8'hFF : r_w[7:0];
    assign interp[8*k +: 8] = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= in_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
    end
  end

  assign res_vld   = p5_vld && p5_warp;
  assign res_we    = !p5_out || cfg.fill_en;
  assign res_pixel = p5_out ? (cfg.fill_en ? (cfg.fill & cfg.chan_mask) : '0)
                            : (PIX_W'(interp) & cfg.chan_mask);

endmodule
